>>> hw/rtl/xec_pkg.sv
// Shared types and entity tables for the XML entity codec.
`timescale 1ns / 1ps

package xec_pkg;

	// Sizes of the entity table, the held prefix and one output run.
	localparam int NUM_ENT = 5;
	localparam int ENT_MAX = 6;
	localparam int PEND_MAX = 5;
	localparam int RUN_MAX = 6;

	// Configuration port geometry and register indexes.
	localparam int ADDR_W = 3;
	localparam logic REG_DIRECTION = 1'b0;

	// Direction codes.
	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	localparam logic [7:0] CH_AMP = 8'h26;

	typedef logic [7:0] octet_t;
	typedef logic [2:0] cnt_t;
	typedef logic [PEND_MAX-1:0][7:0] pend_t;
	typedef logic [RUN_MAX-1:0][7:0] run_t;

	// Character each entity stands for.
	localparam octet_t ENT_CHAR [NUM_ENT] = '{8'h26, 8'h22, 8'h27, 8'h3c, 8'h3e};

	// Length of each entity reference in bytes.
	localparam cnt_t ENT_LEN [NUM_ENT] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd4};

	// Reference text: &amp; &quot; &apos; &lt; &gt; (unused tail bytes are zero).
	localparam octet_t ENT_TEXT [NUM_ENT][ENT_MAX] = '{
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}
	};

	// Configuration state seen by the datapath.
	typedef struct packed {
		logic dir;
		logic wr;
	} cfg_ctrl_t;

	// Outcome of converting one word: the output run and the next prefix.
	typedef struct packed {
		run_t  run;
		cnt_t  cnt;
		pend_t pend;
		cnt_t  pcnt;
	} codec_res_t;

endpackage

>>> hw/rtl/xec_if.sv
// Valid/ready channel interfaces for input and output words of the codec.
`timescale 1ns / 1ps

interface xec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface xec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	modport source(output valid, out_byte, run_end, string_end, input ready);
	modport sink(input valid, out_byte, run_end, string_end, output ready);
endinterface

>>> hw/rtl/xml_entity_codec_unit.sv
// Path: an accepted word passes through the input register and then the result register before it is offered.
// Throughput: one input word per cycle while each yields at most one output word
// and that word is taken; a word that yields a run of k words holds the result
// register until all k are taken, and a held entity prefix byte yields nothing.
// Reset: direction returns to decode, the held prefix and both registers empty.
`timescale 1ns / 1ps

module xml_entity_codec_unit import xec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	xec_in_if.sink            in_ch,
	xec_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_ctrl_t  cfg;
	codec_res_t res;

	logic   valid_s1;
	octet_t byte_s1;
	logic   last_s1;

	pend_t  pend_q;
	cnt_t   pcnt_q;

	run_t   run_q;
	cnt_t   run_len_q;
	cnt_t   run_pos_q;
	logic   run_vld_q;
	logic   run_last_q;

	logic   in_acc;
	logic   out_take;
	logic   run_done;
	logic   run_free;
	logic   process;

	xec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctrl    (cfg)
	);

	xec_core u_core (
		.dir     (cfg.dir),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.pend    (pend_q),
		.pcnt    (pcnt_q),
		.res     (res)
	);

	// Handshake: the result register frees up as its final word is taken.
	assign out_take = run_vld_q && out_ch.ready;
	assign run_done = out_take && (run_pos_q == (run_len_q - 3'd1));
	assign run_free = !run_vld_q || run_done;
	assign process = valid_s1 && (run_free || (res.cnt == 3'd0));
	assign in_ch.ready = !valid_s1 || process;
	assign in_acc = in_ch.valid && in_ch.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// Held entity prefix; a direction write drops it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 3'd0;
		end else if (cfg.wr) begin
			pcnt_q <= 3'd0;
		end else if (process) begin
			pcnt_q <= res.pcnt;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			pend_q <= res.pend;
		end
	end

	// Result register and the position of the word being offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q <= 1'b0;
			run_pos_q <= 3'd0;
			run_len_q <= 3'd0;
		end else if (process && (res.cnt != 3'd0)) begin
			run_vld_q <= 1'b1;
			run_pos_q <= 3'd0;
			run_len_q <= res.cnt;
		end else if (run_done) begin
			run_vld_q <= 1'b0;
		end else if (out_take) begin
			run_pos_q <= run_pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (process && (res.cnt != 3'd0)) begin
			run_q <= res.run;
			run_last_q <= last_s1;
		end
	end

	// Output word.
	assign out_ch.valid = run_vld_q;
	assign out_ch.out_byte = run_q[run_pos_q];
	assign out_ch.run_end = (run_pos_q == (run_len_q - 3'd1));
	assign out_ch.string_end = out_ch.run_end && run_last_q;

	// The offered position always lies inside the loaded run.
	a_pos_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_vld_q |-> (run_pos_q < run_len_q) && (run_len_q <= 3'(RUN_MAX)))
		else $error("output position beyond run length");

	// The held prefix never grows past its storage.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= 3'(PEND_MAX))
		else $error("held prefix count out of range");

	// Encoding never leaves a prefix held.
	a_enc_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(process && (cfg.dir == DIR_ENCODE)) |=> (pcnt_q == 3'd0))
		else $error("prefix held in encode mode");

	// A finished run is either replaced by a fresh one or the register empties.
	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> (!run_vld_q || (run_pos_q == 3'd0)))
		else $error("new run did not start at its first word");

endmodule

>>> hw/rtl/xec_cfg.sv
// APB register block holding the codec direction.
`timescale 1ns / 1ps

module xec_cfg import xec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_ctrl_t         ctrl
);

	logic dir_q;
	logic hit;
	logic wr;

	// Register 0 sits at byte address 0; bit 2 selects the register.
	assign hit = (paddr[2] == REG_DIRECTION);
	assign wr = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_DECODE;
		end else if (wr) begin
			dir_q <= pwdata[0];
		end
	end

	// Reads return the direction bit; other addresses read as zero.
	assign prdata = hit ? {31'd0, dir_q} : 32'd0;
	assign pready = 1'b1;

	assign ctrl.dir = dir_q;
	assign ctrl.wr = wr;

endmodule

>>> hw/rtl/xec_core.sv
// Single-pass conversion of one word against the held entity prefix.
`timescale 1ns / 1ps

module xec_core import xec_pkg::*; (
	input  logic       dir,
	input  octet_t     in_byte,
	input  logic       in_last,
	input  pend_t      pend,
	input  cnt_t       pcnt,
	output codec_res_t res
);

	logic [NUM_ENT-1:0] ent_ok;
	logic [NUM_ENT-1:0] ent_done;
	logic               any_done;
	logic               any_ext;
	octet_t             done_ch;
	logic               enc_hit;
	logic [2:0]         enc_idx;

	// Compare the held prefix plus the new word against every entity.
	always_comb begin
		octet_t nxt;
		for (int r = 0; r < NUM_ENT; r++) begin
			ent_ok[r] = ({1'b0, pcnt} + 4'd1) <= {1'b0, ENT_LEN[r]};
			nxt = 8'd0;
			for (int i = 0; i < ENT_MAX; i++) begin
				if (3'(i) == pcnt) begin
					nxt = ENT_TEXT[r][i];
				end
			end
			if (nxt != in_byte) begin
				ent_ok[r] = 1'b0;
			end
			for (int i = 0; i < PEND_MAX; i++) begin
				if ((3'(i) < pcnt) && (ENT_TEXT[r][i] != pend[i])) begin
					ent_ok[r] = 1'b0;
				end
			end
			ent_done[r] = ent_ok[r] && (({1'b0, pcnt} + 4'd1) == {1'b0, ENT_LEN[r]});
		end
	end

	// Pick the completed entity, if any, and note whether the prefix still grows.
	always_comb begin
		any_done = 1'b0;
		any_ext = 1'b0;
		done_ch = 8'd0;
		for (int r = NUM_ENT - 1; r >= 0; r--) begin
			if (ent_done[r]) begin
				any_done = 1'b1;
				done_ch = ENT_CHAR[r];
			end else if (ent_ok[r]) begin
				any_ext = 1'b1;
			end
		end
	end

	// Look the word up among the escapable characters for encoding.
	always_comb begin
		enc_hit = 1'b0;
		enc_idx = '0;
		for (int r = 0; r < NUM_ENT; r++) begin
			if (ENT_CHAR[r] == in_byte) begin
				enc_hit = 1'b1;
				enc_idx = 3'(r);
			end
		end
	end

	// Assemble the output run and the next prefix state.
	always_comb begin
		logic fresh;
		logic extended;
		res.run = '0;
		res.cnt = 3'd0;
		res.pend = pend;
		res.pcnt = pcnt;
		fresh = 1'b1;
		extended = 1'b0;
		if (dir == DIR_ENCODE) begin
			res.pcnt = 3'd0;
			if (enc_hit) begin
				for (int i = 0; i < ENT_MAX; i++) begin
					res.run[i] = ENT_TEXT[enc_idx][i];
				end
				res.cnt = ENT_LEN[enc_idx];
			end else begin
				res.run[0] = in_byte;
				res.cnt = 3'd1;
			end
		end else begin
			if (pcnt != 3'd0) begin
				if (any_done) begin
					res.run[0] = done_ch;
					res.cnt = 3'd1;
					res.pcnt = 3'd0;
					fresh = 1'b0;
				end else if (any_ext && (pcnt < 3'(PEND_MAX))) begin
					for (int i = 0; i < PEND_MAX; i++) begin
						if (3'(i) == pcnt) begin
							res.pend[i] = in_byte;
						end
					end
					res.pcnt = pcnt + 3'd1;
					fresh = 1'b0;
					extended = 1'b1;
				end else begin
					// Mismatch: the held bytes go out unchanged.
					for (int i = 0; i < PEND_MAX; i++) begin
						res.run[i] = pend[i];
					end
					res.cnt = pcnt;
					res.pcnt = 3'd0;
				end
			end
			if (fresh) begin
				if (in_byte == CH_AMP) begin
					res.pend[0] = in_byte;
					res.pcnt = 3'd1;
				end else begin
					for (int i = 0; i < RUN_MAX; i++) begin
						if (3'(i) == res.cnt) begin
							res.run[i] = in_byte;
						end
					end
					res.cnt = res.cnt + 3'd1;
				end
			end
			// The final word of a string flushes whatever is still held.
			if (in_last) begin
				if (extended) begin
					for (int i = 0; i < PEND_MAX; i++) begin
						res.run[i] = res.pend[i];
					end
					res.cnt = res.pcnt;
					res.pcnt = 3'd0;
				end else if (res.pcnt != 3'd0) begin
					for (int i = 0; i < RUN_MAX; i++) begin
						if (3'(i) == res.cnt) begin
							res.run[i] = CH_AMP;
						end
					end
					res.cnt = res.cnt + 3'd1;
					res.pcnt = 3'd0;
				end
			end
		end
	end

endmodule

>>> tb/tb_xml_entity_codec_unit.sv
// Testbench for the XML entity codec: predicts every output word and checks it.
`timescale 1ns / 1ps

module tb_xml_entity_codec_unit;
	import xec_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS = 22;
	localparam logic [ADDR_W-1:0] DIR_ADDR = ADDR_W'(REG_DIRECTION) << 2;
	localparam logic [ADDR_W-1:0] NO_REG_ADDR = ADDR_W'(4);
	localparam octet_t AMPERSAND = 8'h26;

	// One text word on its way in, and one converted word expected out.
	typedef struct {
		octet_t ch;
		logic   last;
		logic   drain;
	} text_word_t;

	typedef struct {
		octet_t ch;
		logic   run_end;
		logic   str_end;
	} conv_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	xec_in_if  in_ch();
	xec_out_if out_ch();

	xml_entity_codec_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Entity spellings and the characters they stand for.
	string ENTITY_TXT [5] = '{"&amp;", "&quot;", "&apos;", "&lt;", "&gt;"};
	localparam octet_t ENTITY_SYM [5] = '{8'h26, 8'h22, 8'h27, 8'h3c, 8'h3e};

	text_word_t text_in[$];
	conv_word_t expected_words[$];

	// Predictor state: direction and the held entity prefix.
	logic   cur_dir = DIR_DECODE;
	octet_t held [5];
	int     held_n = 0;

	int  mismatches = 0;
	int  queued_words = 0;
	int  cycle_cnt = 0;
	int  send_idle = 0;
	int  recv_stall = 0;
	int  calm_left = 0;
	bit  in_taken = 1'b0;

	always #5 clk = ~clk;

	task automatic note_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Works out the converted words for one accepted text word.
	task automatic predict_word(octet_t b, logic last_mark);
		octet_t run[$];
		octet_t sym;
		bit hit;
		bit part;
		bit done;
		bit ok;
		int n;
		conv_word_t w;
		hit = 1'b0;
		part = 1'b0;
		done = 1'b0;
		sym = '0;
		if (cur_dir == DIR_ENCODE) begin
			held_n = 0;
			for (int r = 0; r < 5; r++) begin
				if (!done && ENTITY_SYM[r] == b) begin
					for (int i = 0; i < ENTITY_TXT[r].len(); i++)
						run = {run, octet_t'(ENTITY_TXT[r][i])};
					done = 1'b1;
				end
			end
			if (!done)
				run = {run, b};
		end else begin
			// Try to extend or complete the held prefix.
			if (held_n > 0) begin
				for (int r = 0; r < 5; r++) begin
					n = ENTITY_TXT[r].len();
					if (held_n + 1 <= n) begin
						ok = 1'b1;
						for (int i = 0; i < held_n; i++)
							if (octet_t'(ENTITY_TXT[r][i]) != held[i])
								ok = 1'b0;
						if (ok && octet_t'(ENTITY_TXT[r][held_n]) == b) begin
							if (held_n + 1 == n) begin
								hit = 1'b1;
								sym = ENTITY_SYM[r];
							end else begin
								part = 1'b1;
							end
						end
					end
				end
				if (hit) begin
					held_n = 0;
					run = {run, sym};
					done = 1'b1;
				end else if (part && held_n < 5) begin
					held[held_n] = b;
					held_n++;
					done = 1'b1;
				end else begin
					for (int i = 0; i < held_n; i++)
						run = {run, held[i]};
					held_n = 0;
				end
			end
			if (!done) begin
				if (b == AMPERSAND) begin
					held[0] = b;
					held_n = 1;
				end else begin
					run = {run, b};
				end
			end
			// The last word of a string flushes whatever is held.
			if (last_mark) begin
				for (int i = 0; i < held_n; i++)
					run = {run, held[i]};
				held_n = 0;
			end
		end
		foreach (run[i]) begin
			w.ch = run[i];
			w.run_end = (i == run.size() - 1);
			w.str_end = (i == run.size() - 1) && last_mark;
			expected_words = {expected_words, w};
		end
	endtask

	// Queues one text word for the driver.
	task automatic add_word(octet_t b, logic last_mark, bit drain_first = 1'b0);
		text_word_t t;
		t.ch = b;
		t.last = last_mark;
		t.drain = drain_first;
		text_in = {text_in, t};
		queued_words++;
	endtask

	task automatic add_string(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			add_word(s[i], last_at_end && (i == s.len() - 1));
	endtask

	// Random decode text, mostly built from whole and partial entities.
	task automatic add_decode_text(bit drain_first);
		octet_t txt[$];
		int ntok;
		int r;
		int cut;
		ntok = $urandom_range(6, 1);
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(4);
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					for (int i = 0; i < ENTITY_TXT[r].len(); i++)
						txt = {txt, octet_t'(ENTITY_TXT[r][i])};
				end
				4, 5: begin
					cut = $urandom_range(ENTITY_TXT[r].len() - 1, 1);
					for (int i = 0; i < cut; i++)
						txt = {txt, octet_t'(ENTITY_TXT[r][i])};
				end
				6: txt = {txt, AMPERSAND};
				default: txt = {txt, octet_t'($urandom_range(255, 1))};
			endcase
		end
		foreach (txt[i])
			add_word(txt[i], i == txt.size() - 1, drain_first && i == 0);
	endtask

	// Random encode text, rich in the five special characters.
	task automatic add_encode_text();
		int len;
		len = $urandom_range(8, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(1))
				add_word(ENTITY_SYM[$urandom_range(4)], i == len - 1);
			else
				add_word(octet_t'($urandom_range(255, 1)), i == len - 1);
		end
	endtask

	// Waits until the block has nothing left to do.
	task automatic settle();
		while (text_in.size() > 0 || in_ch.valid || expected_words.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == DIR_ADDR) begin
			cur_dir = val[0];
			held_n = 0;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads the direction register back and compares it.
	task automatic check_direction();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DIR_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== cur_dir)
			note_mismatch($sformatf("direction reads %b, want %b", prdata[0], cur_dir));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(logic dir, int idle_pct, int stall_pct, bit with_drain);
		int start;
		reg_write(DIR_ADDR, {31'b0, dir});
		check_direction();
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start = queued_words;
		while (queued_words - start < PHASE_WORDS) begin
			if (dir == DIR_ENCODE)
				add_encode_text();
			else
				add_decode_text(with_drain && queued_words - start > PHASE_WORDS / 2);
		end
		settle();
	endtask

	// Driver and receiver: inputs change on the falling edge.
	always @(negedge clk) begin
		text_word_t t;
		if (calm_left > 0)
			calm_left--;
		else if ($urandom_range(49) == 0)
			calm_left = $urandom_range(40, 10);
		out_ch.ready <= arst_n && (calm_left > 0 || $urandom_range(99) >= recv_stall);
		if (!in_ch.valid || in_taken) begin
			in_taken = 1'b0;
			if (arst_n && text_in.size() > 0
			    && (calm_left > 0 || $urandom_range(99) >= send_idle)
			    && !(text_in[0].drain && expected_words.size() > 0)) begin
				t = text_in.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.in_byte <= t.ch;
				in_ch.in_last <= t.last;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Acceptance and checking on the rising edge.
	always @(posedge clk) begin
		conv_word_t w;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				in_taken = 1'b1;
				predict_word(in_ch.in_byte, in_ch.in_last);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					note_mismatch($sformatf("unexpected word %h", out_ch.out_byte));
				end else begin
					w = expected_words.pop_front();
					if (out_ch.out_byte !== w.ch || out_ch.run_end !== w.run_end
					    || out_ch.string_end !== w.str_end)
						note_mismatch($sformatf("got %h/%b/%b, want %h/%b/%b",
							out_ch.out_byte, out_ch.run_end, out_ch.string_end,
							w.ch, w.run_end, w.str_end));
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Decode: complete entities, broken and flushed prefixes.
		add_string("&quot;&amp;", 1'b1);
		add_string("&apo&lt;&gt", 1'b1);
		settle();

		// A held prefix is dropped by a direction write.
		add_string("&a", 1'b0);
		settle();
		reg_write(DIR_ADDR, {31'b0, DIR_DECODE});
		check_direction();
		add_string(";", 1'b0);
		add_word(8'hFF, 1'b1);
		settle();

		// A write past the register list changes nothing.
		reg_write(NO_REG_ADDR, 32'hFFFF_FFFF);
		check_direction();

		// Encode: every special character and the bytes 0x01 and 0xFF.
		reg_write(DIR_ADDR, {31'b0, DIR_ENCODE});
		add_word(8'h01, 1'b0);
		add_string("&\"'<>", 1'b0);
		add_word(8'hFF, 1'b1);
		settle();

		// Random phases under different idling.
		run_phase(DIR_DECODE, 0, 0, 1'b0);
		run_phase(DIR_ENCODE, 82, 0, 1'b0);
		run_phase(DIR_DECODE, 0, 82, 1'b1);
		run_phase(DIR_ENCODE, 38, 38, 1'b0);
		run_phase(DIR_DECODE, 38, 38, 1'b0);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
